@@ rtl/core/prde_pkg.sv @@
package prde_pkg;

    // Storage widths of the offset and slot state
    localparam int OFFSET_BITS  = 28;
    localparam int SLOT_BITS    = 19;
    // Bytes added to the raw packet length by the header
    localparam int HEADER_EXTRA = 14;

    localparam int CFG_DATA_BITS  = 28;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [30:0] BILLION = 31'd1000000000;

    localparam logic [15:0] MISSING_FLAG   = 16'h8000;
    localparam logic [15:0] END_EVENT_FLAG = 16'h4000;
    localparam logic [15:0] SEQ_MAX        = 16'hffff;
    localparam logic [15:0] TRL_MARK       = 16'h8000;
    localparam logic [15:0] TRL_ALL_ONES   = 16'hffff;
    localparam logic [15:0] TRL_MASK_A     = 16'hef00;
    localparam logic [15:0] TRL_MASK_B     = 16'haf00;
    localparam logic [15:0] TRL_MASK_C     = 16'hf000;
    localparam logic [15:0] TRL_PATT_D     = 16'he000;

    // Register reset values
    localparam logic [27:0] DATA_WRAP_RESET  = 28'd200695700;
    localparam logic [27:0] EVENT_WRAP_RESET = 28'd200674620;
    localparam logic [18:0] RING_RESET       = 19'd511986;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CHECK_MISSING   = 3'd0,
        CFG_CHECK_END_EVENT = 3'd1,
        CFG_RATE_ENABLE     = 3'd2,
        CFG_DATA_WRAP_LIMIT = 3'd3,
        CFG_EVENT_WRAP_LIM  = 3'd4,
        CFG_RING_ENTRIES    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic        check_missing;
        logic        check_end_event;
        logic        rate_enable;
        logic [27:0] data_wrap_limit;
        logic [27:0] event_wrap_limit;
        logic [18:0] ring_entries;
    } t_cfg;

    typedef struct packed {
        logic [13:0] packet_length;
        logic [15:0] sequence_count;
        logic [15:0] word_back_26;
        logic [15:0] word_back_24;
        logic [15:0] word_back_22;
        logic [15:0] word_back_20;
        logic [15:0] word_back_14;
        logic [15:0] word_back_10;
        logic [15:0] word_back_6;
        logic        second_tick;
    } t_item;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] write_offset;
        logic [SLOT_BITS-1:0]   slot_index;
        logic [15:0]            wrap_count;
        logic [15:0]            last_sequence;
        logic [31:0]            packet_total;
        logic [29:0]            byte_low_total;
        logic [15:0]            byte_high_total;
        logic [31:0]            missing_total;
        logic [31:0]            second_sum;
        logic [31:0]            latched_rate;
        logic                   tick_seen;
    } t_state;

    typedef struct packed {
        logic [18:0] ring_slot;
        logic [27:0] data_offset;
        logic [15:0] descriptor_word;
        logic [14:0] stored_length;
        logic [27:0] next_offset;
        logic [31:0] packets_received;
        logic [29:0] bytes_low;
        logic [15:0] bytes_billions;
        logic [31:0] packets_missing;
        logic [31:0] bit_rate;
    } t_result;

endpackage

@@ rtl/core/prde_calc.sv @@
module prde_calc (
    input  prde_pkg::t_cfg    i_cfg,
    input  prde_pkg::t_item   i_item,
    input  prde_pkg::t_state  i_state,
    output prde_pkg::t_state  o_state,
    output prde_pkg::t_result o_result
);

    logic [14:0]                 w_full_len;
    logic [14:0]                 w_stored;
    logic [30:0]                 w_byte_sum;
    logic                        w_in_seq;
    logic                        w_miss;
    logic                        w_eev;
    logic [prde_pkg::OFFSET_BITS:0] w_adv_offset;
    logic [prde_pkg::SLOT_BITS:0]   w_adv_slot;
    logic                        w_wrap;
    logic [31:0]                 w_sum_next;

    // Lengths with header bytes
    assign w_full_len = 15'(i_item.packet_length) + 15'(prde_pkg::HEADER_EXTRA);
    assign w_stored   = w_full_len - 15'd2;

    // Sequence gap check, skipped on the very first slot after reset and on a wrap from SEQ_MAX to zero
    assign w_in_seq = (i_state.last_sequence != prde_pkg::SEQ_MAX) &&
                      ((i_state.last_sequence + 16'd1) == i_item.sequence_count);
    assign w_miss = i_cfg.check_missing && !w_in_seq &&
                    ((i_state.slot_index != '0) || (i_state.wrap_count != '0)) &&
                    ((i_state.last_sequence != prde_pkg::SEQ_MAX) ||
                     (i_item.sequence_count != '0));

    // End-of-event trailer patterns
    assign w_eev = i_cfg.check_end_event && (
        ((i_item.word_back_26 == prde_pkg::TRL_MARK) &&
         (i_item.word_back_24 == prde_pkg::TRL_MARK) &&
         (i_item.word_back_22 == prde_pkg::TRL_ALL_ONES) &&
         (i_item.word_back_20 == prde_pkg::TRL_MARK)) ||
        (((i_item.word_back_14 & prde_pkg::TRL_MASK_A) == prde_pkg::TRL_MASK_A) &&
         ((i_item.word_back_14 & prde_pkg::TRL_MASK_B) == prde_pkg::TRL_MASK_B)) ||
        (((i_item.word_back_10 & prde_pkg::TRL_MASK_C) == prde_pkg::TRL_MASK_C) &&
         ((i_item.word_back_6 & prde_pkg::TRL_MASK_C) == prde_pkg::TRL_PATT_D)));

    // Advance offset and slot, compare before truncation
    assign w_adv_offset = {1'b0, i_state.write_offset} +
                          (prde_pkg::OFFSET_BITS+1)'(w_stored);
    assign w_adv_slot   = {1'b0, i_state.slot_index} + (prde_pkg::SLOT_BITS+1)'(1);
    assign w_wrap = (w_eev && (w_adv_offset > (prde_pkg::OFFSET_BITS+1)'(i_cfg.event_wrap_limit)))
                 || (w_adv_offset > (prde_pkg::OFFSET_BITS+1)'(i_cfg.data_wrap_limit))
                 || (w_adv_slot >= (prde_pkg::SLOT_BITS+1)'(i_cfg.ring_entries));

    assign w_byte_sum = {1'b0, i_state.byte_low_total} + 31'(w_full_len);
    assign w_sum_next = i_state.second_sum + 32'(w_full_len);

    // Next state
    always_comb begin
        o_state = i_state;
        o_state.packet_total = i_state.packet_total + 32'd1;
        if (w_byte_sum > prde_pkg::BILLION) begin
            o_state.byte_low_total  = 30'(w_byte_sum - prde_pkg::BILLION);
            o_state.byte_high_total = i_state.byte_high_total + 16'd1;
        end else begin
            o_state.byte_low_total = w_byte_sum[29:0];
        end
        if (i_cfg.rate_enable) begin
            o_state.second_sum = w_sum_next;
            if (!i_item.second_tick) begin
                o_state.tick_seen = 1'b0;
            end else if (!i_state.tick_seen) begin
                o_state.latched_rate = {w_sum_next[28:0], 3'b000};
                o_state.second_sum   = '0;
                o_state.tick_seen    = 1'b1;
            end
        end
        if (i_cfg.check_missing) begin
            o_state.last_sequence = i_item.sequence_count;
        end
        if (w_miss) begin
            o_state.missing_total = i_state.missing_total + 32'd1;
        end
        if (w_wrap) begin
            o_state.write_offset = '0;
            o_state.slot_index   = '0;
            o_state.wrap_count   = i_state.wrap_count + 16'd1;
        end else begin
            o_state.write_offset = w_adv_offset[prde_pkg::OFFSET_BITS-1:0];
            o_state.slot_index   = w_adv_slot[prde_pkg::SLOT_BITS-1:0];
        end
    end

    // Descriptor for this transfer, counters as seen after it
    always_comb begin
        o_result.ring_slot        = 19'(i_state.slot_index);
        o_result.data_offset      = 28'(i_state.write_offset);
        o_result.descriptor_word  = i_state.wrap_count |
                                    (w_miss ? prde_pkg::MISSING_FLAG : 16'd0) |
                                    (w_eev ? prde_pkg::END_EVENT_FLAG : 16'd0);
        o_result.stored_length    = w_stored;
        o_result.next_offset      = 28'(o_state.write_offset);
        o_result.packets_received = o_state.packet_total;
        o_result.bytes_low        = o_state.byte_low_total;
        o_result.bytes_billions   = o_state.byte_high_total;
        o_result.packets_missing  = o_state.missing_total;
        o_result.bit_rate         = o_state.latched_rate;
    end

endmodule

@@ rtl/core/packet_ring_descriptor_engine_top.sv @@
// Packet ring descriptor engine.
// Input channel: one transfer per received packet (length, sequence counter,
// trailer words, second tick), taken when i_in_valid is high and o_in_stall low.
// Output channel: one descriptor per packet (slot, offsets, descriptor word,
// stored length and running counters), taken when o_out_valid is high and
// i_out_stall low.
// A packet accepted into the input register moves on to the output register
// when that register is free. Throughput: one packet per cycle while the output
// is not stalled, set by the state update between the input and result registers.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data at the
// clock edge; write only while no packet is in flight.
// Reset (i_rst_n low, synchronous): pipeline empties, all counters, offset,
// slot and wrap count clear, flags go to 1 and limits to their defaults.
// Stall: while i_out_stall holds a waiting descriptor, one more packet is
// held in the input register; after that o_in_stall rises until the output
// drains. No packet is lost or repeated.
module packet_ring_descriptor_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [prde_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [prde_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [13:0] i_packet_length,
    input  logic [15:0] i_sequence_count,
    input  logic [15:0] i_word_back_26,
    input  logic [15:0] i_word_back_24,
    input  logic [15:0] i_word_back_22,
    input  logic [15:0] i_word_back_20,
    input  logic [15:0] i_word_back_14,
    input  logic [15:0] i_word_back_10,
    input  logic [15:0] i_word_back_6,
    input  logic        i_second_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [18:0] o_ring_slot,
    output logic [27:0] o_data_offset,
    output logic [15:0] o_descriptor_word,
    output logic [14:0] o_stored_length,
    output logic [27:0] o_next_offset,
    output logic [31:0] o_packets_received,
    output logic [29:0] o_bytes_low,
    output logic [15:0] o_bytes_billions,
    output logic [31:0] o_packets_missing,
    output logic [31:0] o_bit_rate
);

    prde_pkg::t_cfg    r_cfg;
    prde_pkg::t_state  r_state;
    prde_pkg::t_state  n_state;
    prde_pkg::t_item   r_item;
    prde_pkg::t_result r_result;
    prde_pkg::t_result n_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_out_ready;
    logic              w_in_ready;

    // Pipeline flow control
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_in_ready  = !r_in_valid || w_out_ready;
    assign o_in_stall  = !w_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_missing    <= 1'b1;
            r_cfg.check_end_event  <= 1'b1;
            r_cfg.rate_enable      <= 1'b1;
            r_cfg.data_wrap_limit  <= prde_pkg::DATA_WRAP_RESET;
            r_cfg.event_wrap_limit <= prde_pkg::EVENT_WRAP_RESET;
            r_cfg.ring_entries     <= prde_pkg::RING_RESET;
        end else if (i_cfg_we) begin
            unique case (prde_pkg::t_cfg_index'(i_cfg_index))
                prde_pkg::CFG_CHECK_MISSING:   r_cfg.check_missing    <= i_cfg_data[0];
                prde_pkg::CFG_CHECK_END_EVENT: r_cfg.check_end_event  <= i_cfg_data[0];
                prde_pkg::CFG_RATE_ENABLE:     r_cfg.rate_enable      <= i_cfg_data[0];
                prde_pkg::CFG_DATA_WRAP_LIMIT: r_cfg.data_wrap_limit  <= i_cfg_data;
                prde_pkg::CFG_EVENT_WRAP_LIM:  r_cfg.event_wrap_limit <= i_cfg_data;
                prde_pkg::CFG_RING_ENTRIES:    r_cfg.ring_entries     <= i_cfg_data[18:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the incoming transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_item.packet_length  <= i_packet_length;
            r_item.sequence_count <= i_sequence_count;
            r_item.word_back_26   <= i_word_back_26;
            r_item.word_back_24   <= i_word_back_24;
            r_item.word_back_22   <= i_word_back_22;
            r_item.word_back_20   <= i_word_back_20;
            r_item.word_back_14   <= i_word_back_14;
            r_item.word_back_10   <= i_word_back_10;
            r_item.word_back_6    <= i_word_back_6;
            r_item.second_tick    <= i_second_tick;
        end
    end

    prde_calc u_calc (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Advance state as the held packet moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_ring_slot        = r_result.ring_slot;
    assign o_data_offset      = r_result.data_offset;
    assign o_descriptor_word  = r_result.descriptor_word;
    assign o_stored_length    = r_result.stored_length;
    assign o_next_offset      = r_result.next_offset;
    assign o_packets_received = r_result.packets_received;
    assign o_bytes_low        = r_result.bytes_low;
    assign o_bytes_billions   = r_result.bytes_billions;
    assign o_packets_missing  = r_result.packets_missing;
    assign o_bit_rate         = r_result.bit_rate;

endmodule
